@@ hw/rtl/ilp_pkg.sv @@
package ilp_pkg;

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE        = 7'b0000001,
    PH_START       = 7'b0000010,
    PH_LEAD_COLON  = 7'b0000100,
    PH_GROUP_START = 7'b0001000,
    PH_IN_GROUP    = 7'b0010000,
    PH_AFTER_COLON = 7'b0100000,
    PH_IN_OCTET    = 7'b1000000
  } phase_t;

  localparam int unsigned NUM_GROUPS   = 8;
  localparam int unsigned GROUP_W      = 16;
  localparam int unsigned ADDR_W       = NUM_GROUPS * GROUP_W;
  localparam int unsigned MAX_HEX_DIG  = 4;
  localparam int unsigned MAX_DEC_DIG  = 3;
  localparam int unsigned MAX_PRE_QUAD = 6;
  localparam int unsigned MAX_COMP     = 7;

  localparam logic [9:0] OCTET_MAX = 10'd255;
  localparam logic [9:0] DEC_SAT   = 10'd1023;
  localparam logic [13:0] DEC_LIM  = 14'd999;
  localparam logic [3:0] DEC_BASE  = 4'd10;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef logic [GROUP_W-1:0] group_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c inside {[8'h30:8'h39]}) v = {1'b0, c[3:0]};
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

@@ hw/rtl/ipv6_literal_parser.sv @@
// Bracketed IPv6 literal parser, one character per request.
// A request is captured in the input register when accepted, and its result (if any)
// is loaded into the output register when the held request is processed.
// Throughput: one character per cycle; the input stalls only while a result sits
// in the output register with out_stall high.
// Reset (synchronous, rst_n low): block goes idle, ignores characters until first.
module ipv6_literal_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char_byte,
  input  logic                 in_first,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_addr_high,
  output logic [63:0]          out_addr_low,
  output logic                 out_status
);
  import ilp_pkg::*;

  // Input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       in_first_r;

  // Parse state
  phase_t              phase_r, phase_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [3:0]          head_tot_r, head_tot_nxt;
  logic [3:0]          tail_tot_r, tail_tot_nxt;
  logic                comp_r, comp_nxt;
  group_t              gacc_r, gacc_nxt;
  logic [2:0]          gdig_r, gdig_nxt;
  logic [9:0]          dacc_r, dacc_nxt;
  logic                alldec_r, alldec_nxt;
  logic [31:0]         quad_r, quad_nxt;
  logic [1:0]          oidx_r, oidx_nxt;

  // Output register
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_hi_r;
  logic [63:0] out_lo_r;
  logic        out_st_r;

  // Step logic
  logic              fire;
  logic              in_take;
  logic [7:0]        c;
  logic [4:0]        hv;
  logic              c_hex;
  logic              c_dec;
  logic [4:0]        total;
  logic [4:0]        fin_total;
  logic [13:0]       dec_prod;
  logic [1:0]        push_cnt;
  group_t            push_a, push_b;
  logic              do_finish, do_error;
  logic              res_vld, res_err;
  logic [ADDR_W-1:0] res_addr;
  logic [31:0]       quad_fin;

  // Process the held request when the result register is free or draining.
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  assign c     = in_char_r;
  assign hv    = hex_val(c);
  assign c_hex = !hv[4];
  assign c_dec = is_dec(c);

  always_comb begin
    // Start from the live state, or from cleared state on the first character.
    if (in_first_r) begin
      phase_nxt    = PH_START;
      head_nxt     = '0;
      tail_nxt     = '0;
      head_tot_nxt = '0;
      tail_tot_nxt = '0;
      comp_nxt     = 1'b0;
      gacc_nxt     = '0;
      gdig_nxt     = '0;
      dacc_nxt     = '0;
      alldec_nxt   = 1'b1;
      quad_nxt     = '0;
      oidx_nxt     = '0;
    end else begin
      phase_nxt    = phase_r;
      head_nxt     = head_r;
      tail_nxt     = tail_r;
      head_tot_nxt = head_tot_r;
      tail_tot_nxt = tail_tot_r;
      comp_nxt     = comp_r;
      gacc_nxt     = gacc_r;
      gdig_nxt     = gdig_r;
      dacc_nxt     = dacc_r;
      alldec_nxt   = alldec_r;
      quad_nxt     = quad_r;
      oidx_nxt     = oidx_r;
    end

    total     = {1'b0, head_tot_nxt} + {1'b0, tail_tot_nxt};
    dec_prod  = 14'(dacc_nxt * DEC_BASE) + {10'b0, c[3:0]};
    push_cnt  = 2'd0;
    push_a    = gacc_nxt;
    push_b    = '0;
    do_finish = 1'b0;
    do_error  = 1'b0;
    quad_fin  = {quad_nxt[31:8], dacc_nxt[7:0]};

    case (phase_nxt)
      PH_IDLE: begin
      end
      PH_START, PH_GROUP_START, PH_AFTER_COLON: begin
        if (phase_nxt == PH_START && c == CH_COLON) begin
          phase_nxt = PH_LEAD_COLON;
        end else if (phase_nxt == PH_AFTER_COLON && c == CH_COLON) begin
          // second '::' is malformed
          if (comp_nxt) begin
            do_error = 1'b1;
          end else begin
            comp_nxt  = 1'b1;
            phase_nxt = PH_GROUP_START;
          end
        end else if (phase_nxt != PH_AFTER_COLON && c == CH_RBRACK) begin
          do_finish = 1'b1;
        end else if (total >= 5'(NUM_GROUPS) || !c_hex) begin
          do_error = 1'b1;
        end else begin
          // open a new group
          gacc_nxt   = {12'b0, hv[3:0]};
          gdig_nxt   = 3'd1;
          alldec_nxt = c_dec;
          dacc_nxt   = c_dec ? {6'b0, c[3:0]} : '0;
          phase_nxt  = PH_IN_GROUP;
        end
      end
      PH_LEAD_COLON: begin
        if (c != CH_COLON) begin
          do_error = 1'b1;
        end else begin
          comp_nxt  = 1'b1;
          phase_nxt = PH_GROUP_START;
        end
      end
      PH_IN_GROUP: begin
        if (c_hex) begin
          if (gdig_nxt >= 3'(MAX_HEX_DIG)) begin
            do_error = 1'b1;
          end else begin
            gacc_nxt = {gacc_nxt[11:0], hv[3:0]};
            gdig_nxt = gdig_nxt + 3'd1;
            if (c_dec && alldec_nxt) begin
              // saturate so a long decimal run stays out of octet range
              dacc_nxt = (dec_prod > DEC_LIM) ? DEC_SAT : dec_prod[9:0];
            end else begin
              alldec_nxt = 1'b0;
            end
          end
        end else if (c == CH_DOT) begin
          if (!alldec_nxt || gdig_nxt > 3'(MAX_DEC_DIG) || dacc_nxt > OCTET_MAX) begin
            do_error = 1'b1;
          end else begin
            quad_nxt  = {dacc_nxt[7:0], 24'b0};
            oidx_nxt  = 2'd1;
            gdig_nxt  = '0;
            dacc_nxt  = '0;
            phase_nxt = PH_IN_OCTET;
          end
        end else if (c == CH_COLON) begin
          push_cnt  = 2'd1;
          phase_nxt = PH_AFTER_COLON;
        end else if (c == CH_RBRACK) begin
          push_cnt  = 2'd1;
          do_finish = 1'b1;
        end else begin
          do_error = 1'b1;
        end
      end
      PH_IN_OCTET: begin
        if (c_dec) begin
          if (gdig_nxt >= 3'(MAX_DEC_DIG)) begin
            do_error = 1'b1;
          end else begin
            dacc_nxt = dec_prod[9:0];
            gdig_nxt = gdig_nxt + 3'd1;
          end
        end else if (gdig_nxt == 3'd0 || dacc_nxt > OCTET_MAX) begin
          do_error = 1'b1;
        end else if (oidx_nxt != 2'd3) begin
          if (c != CH_DOT) begin
            do_error = 1'b1;
          end else begin
            if (oidx_nxt == 2'd1) quad_nxt[23:16] = dacc_nxt[7:0];
            else                  quad_nxt[15:8]  = dacc_nxt[7:0];
            oidx_nxt = oidx_nxt + 2'd1;
            gdig_nxt = '0;
            dacc_nxt = '0;
          end
        end else if (c != CH_RBRACK || total > 5'(MAX_PRE_QUAD)) begin
          do_error = 1'b1;
        end else begin
          // dotted quad lands as two groups
          quad_nxt  = quad_fin;
          push_cnt  = 2'd2;
          push_a    = quad_fin[31:16];
          push_b    = quad_fin[15:0];
          do_finish = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Push groups: tail shifts in from the low end, head fills by position.
    if (push_cnt != 2'd0) begin
      if (comp_nxt) begin
        if (push_cnt == 2'd2) begin
          tail_nxt     = {tail_nxt[ADDR_W-2*GROUP_W-1:0], push_a, push_b};
          tail_tot_nxt = tail_tot_nxt + 4'd2;
        end else if (tail_tot_nxt < 4'(NUM_GROUPS)) begin
          tail_nxt     = {tail_nxt[ADDR_W-GROUP_W-1:0], push_a};
          tail_tot_nxt = tail_tot_nxt + 4'd1;
        end
      end else begin
        for (int k = 0; k < NUM_GROUPS; k++) begin
          if (4'(k) == head_tot_nxt)
            head_nxt[ADDR_W-1-k*GROUP_W -: GROUP_W] = push_a;
          else if (push_cnt == 2'd2 && 4'(k) == head_tot_nxt + 4'd1)
            head_nxt[ADDR_W-1-k*GROUP_W -: GROUP_W] = push_b;
        end
        if (push_cnt == 2'd2)
          head_tot_nxt = head_tot_nxt + 4'd2;
        else if (head_tot_nxt < 4'(NUM_GROUPS))
          head_tot_nxt = head_tot_nxt + 4'd1;
      end
    end

    // Closing check: '::' must cover at least one zero group.
    fin_total = {1'b0, head_tot_nxt} + {1'b0, tail_tot_nxt};
    if (do_finish) begin
      if (comp_nxt ? (fin_total > 5'(MAX_COMP)) : (fin_total != 5'(NUM_GROUPS)))
        do_error = 1'b1;
    end

    res_vld  = do_finish || do_error;
    res_err  = do_error;
    res_addr = do_error ? '0 : (head_nxt | tail_nxt);
    if (res_vld) phase_nxt = PH_IDLE;
  end

  // Input register: hold while the result side is blocked.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take)   in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  // Result register: load on a produced result, drop once taken.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire && res_vld)  out_vld_nxt = 1'b1;
    else if (!out_stall)  out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= PH_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      head_tot_r <= '0;
      tail_tot_r <= '0;
      comp_r     <= 1'b0;
      gacc_r     <= '0;
      gdig_r     <= '0;
      dacc_r     <= '0;
      alldec_r   <= 1'b1;
      quad_r     <= '0;
      oidx_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        phase_r    <= phase_nxt;
        head_r     <= head_nxt;
        tail_r     <= tail_nxt;
        head_tot_r <= head_tot_nxt;
        tail_tot_r <= tail_tot_nxt;
        comp_r     <= comp_nxt;
        gacc_r     <= gacc_nxt;
        gdig_r     <= gdig_nxt;
        dacc_r     <= dacc_nxt;
        alldec_r   <= alldec_nxt;
        quad_r     <= quad_nxt;
        oidx_r     <= oidx_nxt;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r  <= in_char_byte;
      in_first_r <= in_first;
    end
    if (fire && res_vld) begin
      out_hi_r <= res_addr[ADDR_W-1:ADDR_W/2];
      out_lo_r <= res_addr[ADDR_W/2-1:0];
      out_st_r <= res_err;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_addr_high = out_hi_r;
  assign out_addr_low  = out_lo_r;
  assign out_status    = out_st_r;

endmodule
